// ===== design/itp_pkg.sv =====
// Shared types, character codes and operator tables for the infix-to-postfix converter.
`default_nettype none

package itp_pkg;

  // Default operator stack depth
  localparam int STACK_DEPTH = 32;

  // Width of one stacked operator code
  localparam int CODE_W = 3;

  // ASCII characters recognized by the converter
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_ADD   = 8'h2B;
  localparam logic [7:0] CH_SUB   = 8'h2D;
  localparam logic [7:0] CH_MUL   = 8'h2A;
  localparam logic [7:0] CH_DIV   = 8'h2F;
  localparam logic [7:0] CH_POW   = 8'h5E;
  localparam logic [7:0] CH_NONE  = 8'h00;

  // End marker status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_PAREN    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  // Stacked operator codes
  typedef enum logic [CODE_W-1:0] {
    OP_OPEN = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_POW  = 3'd5
  } op_code_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLOSE,
    ST_OPPOP,
    ST_FLUSH,
    ST_DRAIN
  } state_t;

  // Input beat
  typedef struct packed {
    logic [7:0] symbol;
    logic       final_char;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    logic [7:0] out_symbol;
    logic       end_marker;
    logic [1:0] status;
    logic       last_of_run;
  } out_beat_t;

  // Sequencer to output stage
  typedef struct packed {
    logic      emit;
    logic      drain;
    out_beat_t beat;
  } gen_t;

  // Output stage to sequencer
  typedef struct packed {
    logic can_emit;
    logic hold_valid;
    logic out_free;
  } ostat_t;

  // ASCII character of an operator code
  function automatic logic [7:0] code_char(input op_code_t code);
    logic [7:0] ch;
    unique case (code)
      OP_OPEN: ch = CH_OPEN;
      OP_ADD:  ch = CH_ADD;
      OP_SUB:  ch = CH_SUB;
      OP_MUL:  ch = CH_MUL;
      OP_DIV:  ch = CH_DIV;
      OP_POW:  ch = CH_POW;
      default: ch = CH_NONE;
    endcase
    return ch;
  endfunction

  // Precedence of an operator code; open parenthesis ranks lowest
  function automatic logic [1:0] code_prec(input op_code_t code);
    logic [1:0] p;
    unique case (code)
      OP_ADD, OP_SUB: p = 2'd1;
      OP_MUL, OP_DIV: p = 2'd2;
      OP_POW:         p = 2'd3;
      default:        p = 2'd0;
    endcase
    return p;
  endfunction

  // Operator code of an input character, open code when not an operator
  function automatic op_code_t char_code(input logic [7:0] ch);
    op_code_t c;
    unique case (ch)
      CH_ADD:  c = OP_ADD;
      CH_SUB:  c = OP_SUB;
      CH_MUL:  c = OP_MUL;
      CH_DIV:  c = OP_DIV;
      CH_POW:  c = OP_POW;
      default: c = OP_OPEN;
    endcase
    return c;
  endfunction

  // Letter test
  function automatic logic is_letter(input logic [7:0] ch);
    return ((ch >= 8'h41) && (ch <= 8'h5A)) || ((ch >= 8'h61) && (ch <= 8'h7A));
  endfunction

endpackage

`default_nettype wire

// ===== design/itp_stack_mem.sv =====
// Operator stack memory: one write port, one registered read port with write-first forwarding.
`default_nettype none

module itp_stack_mem #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH,
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  wire logic                      clk,
  input  wire logic                      we,
  input  wire logic [AW-1:0]             waddr,
  input  wire logic [itp_pkg::CODE_W-1:0] wdata,
  input  wire logic [AW-1:0]             raddr,
  output logic      [itp_pkg::CODE_W-1:0] rdata
);

  logic [itp_pkg::CODE_W-1:0] mem [STACK_DEPTH];

  // Write the pushed code
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read the top entry, forwarding a same-cycle push
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== design/itp_out_stage.sv =====
// Result hold register and output register; tags the last result of each input item.
`default_nettype none

module itp_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire itp_pkg::gen_t      gen,
  output itp_pkg::ostat_t         ostat,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output itp_pkg::out_beat_t      out_item
);

  logic               hold_valid;
  itp_pkg::out_beat_t hold;
  logic               out_free;
  logic               load_next;
  logic               load_last;

  // Status toward the sequencer
  assign out_free         = !out_valid || out_ready;
  assign ostat.out_free   = out_free;
  assign ostat.hold_valid = hold_valid;
  assign ostat.can_emit   = !hold_valid || out_free;

  // Move the held result out: plain when another follows, tagged last on drain
  assign load_next = gen.emit && hold_valid && out_free;
  assign load_last = !gen.emit && gen.drain && hold_valid && out_free;

  // Control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (load_next || load_last) begin
        out_valid <= 1'b1;
      end else if (out_free) begin
        out_valid <= 1'b0;
      end
      if (gen.emit && ostat.can_emit) begin
        hold_valid <= 1'b1;
      end else if (load_last) begin
        hold_valid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (gen.emit && ostat.can_emit) begin
      hold <= gen.beat;
    end
    if (load_next || load_last) begin
      out_item <= '{out_symbol:  hold.out_symbol,
                    end_marker:  hold.end_marker,
                    status:      hold.status,
                    last_of_run: load_last};
    end
  end

endmodule

`default_nettype wire

// ===== design/itp_ctrl.sv =====
// Sequencer: classifies characters, pops and pushes the operator stack one entry per cycle, held on output stall.
`default_nettype none

module itp_ctrl #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH,
  localparam int AW   = $clog2(STACK_DEPTH),
  localparam int SP_W = $clog2(STACK_DEPTH + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire itp_pkg::in_beat_t          in_item,
  input  wire itp_pkg::ostat_t            ostat,
  output itp_pkg::gen_t                   gen,
  output logic                            we,
  output logic      [AW-1:0]              waddr,
  output logic      [itp_pkg::CODE_W-1:0] wdata,
  output logic      [AW-1:0]              raddr,
  input  wire logic [itp_pkg::CODE_W-1:0] rdata
);

  itp_pkg::state_t   state, state_next;
  logic [SP_W-1:0]   sp, sp_next;
  logic [1:0]        err, err_next;
  itp_pkg::op_code_t cur, cur_next;
  logic              fin, fin_next;
  itp_pkg::op_code_t top;
  itp_pkg::op_code_t push_code;
  logic              do_push;
  logic              raise;
  logic [1:0]        raise_code;
  logic              stack_empty;

  assign top         = itp_pkg::op_code_t'(rdata);
  assign stack_empty = (sp == '0);
  assign waddr       = AW'(sp);
  assign wdata       = push_code;

  // Read the entry that will be on top next cycle
  assign raddr = (sp_next == '0) ? '0 : AW'(sp_next - SP_W'(1));

  // State and stack registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= itp_pkg::ST_IDLE;
      sp    <= '0;
      err   <= itp_pkg::STATUS_OK;
    end else begin
      state <= state_next;
      sp    <= sp_next;
      err   <= err_next;
    end
  end

  // Item registers
  always_ff @(posedge clk) begin
    cur <= cur_next;
    fin <= fin_next;
  end

  // Next state, stack moves and results
  always_comb begin
    state_next = state;
    sp_next    = sp;
    err_next   = err;
    cur_next   = cur;
    fin_next   = fin;
    in_ready   = 1'b0;
    gen        = '0;
    do_push    = 1'b0;
    push_code  = cur;
    raise      = 1'b0;
    raise_code = itp_pkg::STATUS_OK;
    we         = 1'b0;

    unique case (state)
      itp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          fin_next   = in_item.final_char;
          state_next = in_item.final_char ? itp_pkg::ST_FLUSH : itp_pkg::ST_DRAIN;
          if (itp_pkg::is_letter(in_item.symbol)) begin
            gen.emit            = 1'b1;
            gen.beat.out_symbol = in_item.symbol;
          end else if (in_item.symbol == itp_pkg::CH_OPEN) begin
            do_push   = 1'b1;
            push_code = itp_pkg::OP_OPEN;
          end else if (in_item.symbol == itp_pkg::CH_CLOSE) begin
            state_next = itp_pkg::ST_CLOSE;
          end else if (itp_pkg::char_code(in_item.symbol) != itp_pkg::OP_OPEN) begin
            cur_next   = itp_pkg::char_code(in_item.symbol);
            state_next = itp_pkg::ST_OPPOP;
          end
        end
      end

      // Pop down to the matching open parenthesis
      itp_pkg::ST_CLOSE: begin
        if (stack_empty) begin
          raise      = 1'b1;
          raise_code = itp_pkg::STATUS_PAREN;
          state_next = fin ? itp_pkg::ST_FLUSH : itp_pkg::ST_DRAIN;
        end else if (top == itp_pkg::OP_OPEN) begin
          sp_next    = sp - SP_W'(1);
          state_next = fin ? itp_pkg::ST_FLUSH : itp_pkg::ST_DRAIN;
        end else if (ostat.can_emit) begin
          gen.emit            = 1'b1;
          gen.beat.out_symbol = itp_pkg::code_char(top);
          sp_next             = sp - SP_W'(1);
        end
      end

      // Pop operators of equal or higher precedence, then push
      itp_pkg::ST_OPPOP: begin
        if (stack_empty || (top == itp_pkg::OP_OPEN) ||
            (itp_pkg::code_prec(top) < itp_pkg::code_prec(cur))) begin
          do_push    = 1'b1;
          state_next = fin ? itp_pkg::ST_FLUSH : itp_pkg::ST_DRAIN;
        end else if (ostat.can_emit) begin
          gen.emit            = 1'b1;
          gen.beat.out_symbol = itp_pkg::code_char(top);
          sp_next             = sp - SP_W'(1);
        end
      end

      // Empty the stack, then close the expression
      itp_pkg::ST_FLUSH: begin
        if (stack_empty) begin
          if (ostat.can_emit) begin
            gen.emit            = 1'b1;
            gen.beat.out_symbol = itp_pkg::CH_NONE;
            gen.beat.end_marker = 1'b1;
            gen.beat.status     = err;
            err_next            = itp_pkg::STATUS_OK;
            state_next          = itp_pkg::ST_DRAIN;
          end
        end else if (top == itp_pkg::OP_OPEN) begin
          raise      = 1'b1;
          raise_code = itp_pkg::STATUS_PAREN;
          sp_next    = sp - SP_W'(1);
        end else if (ostat.can_emit) begin
          gen.emit            = 1'b1;
          gen.beat.out_symbol = itp_pkg::code_char(top);
          sp_next             = sp - SP_W'(1);
        end
      end

      // Send the held result out as the last one of the item
      itp_pkg::ST_DRAIN: begin
        gen.drain = 1'b1;
        if (!ostat.hold_valid || ostat.out_free) begin
          state_next = itp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = itp_pkg::ST_IDLE;
      end
    endcase

    // Push, or flag overflow on a full stack
    if (do_push) begin
      if (sp >= SP_W'(STACK_DEPTH)) begin
        raise      = 1'b1;
        raise_code = itp_pkg::STATUS_OVERFLOW;
      end else begin
        we      = 1'b1;
        sp_next = sp + SP_W'(1);
      end
    end

    // Keep the first error of the expression
    if (raise && (err == itp_pkg::STATUS_OK)) begin
      err_next = raise_code;
    end
  end

endmodule

`default_nettype wire

// ===== design/infix_to_postfix_converter.sv =====
// Infix to postfix converter top level: sequencer, operator stack memory and output stage.
// A letter passes from the sequencer into the hold register, then the output register.
// A new input beat is taken only when idle; an operator or ')' adds a state, and each popped
// operator, flushed entry and end marker is its own step; one pop a cycle, held on stall.
// Reset clears the stack pointer, error status, sequencer and output flags; the stack
// memory itself is not cleared and needs no clearing pass.
`default_nettype none

module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire itp_pkg::in_beat_t  in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output itp_pkg::out_beat_t      out_item
);

  localparam int AW = $clog2(STACK_DEPTH);

  itp_pkg::gen_t              gen;
  itp_pkg::ostat_t            ostat;
  logic                       we;
  logic [AW-1:0]              waddr;
  logic [AW-1:0]              raddr;
  logic [itp_pkg::CODE_W-1:0] wdata;
  logic [itp_pkg::CODE_W-1:0] rdata;

  // Sequencer
  itp_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .ostat    (ostat),
    .gen      (gen),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .raddr    (raddr),
    .rdata    (rdata)
  );

  // Operator stack
  itp_stack_mem #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Result hold and output register
  itp_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .gen       (gen),
    .ostat     (ostat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Self-checking testbench for the infix to postfix converter.
module tb;
  import itp_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int RAND_BEATS   = 200;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_GAP      = 18;
  localparam int DIR_ROWS     = 25;

  // One row of the directed stimulus; want is used only when typed is set
  typedef struct packed {
    logic [7:0] sym;
    logic       fin;
    logic       typed;
    out_beat_t  want;
  } dir_row_t;

  localparam out_beat_t NO_WANT = '0;

  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{"A",      1'b0, 1'b1, '{"A",     1'b0, STATUS_OK,    1'b1}},
    '{"Z",      1'b0, 1'b1, '{"Z",     1'b0, STATUS_OK,    1'b1}},
    '{"a",      1'b0, 1'b1, '{"a",     1'b0, STATUS_OK,    1'b1}},
    '{"z",      1'b0, 1'b1, '{"z",     1'b0, STATUS_OK,    1'b1}},
    '{CH_ADD,   1'b0, 1'b0, NO_WANT},
    '{"b",      1'b0, 1'b0, NO_WANT},
    '{CH_MUL,   1'b0, 1'b0, NO_WANT},
    '{"c",      1'b0, 1'b0, NO_WANT},
    '{CH_POW,   1'b0, 1'b0, NO_WANT},
    '{"d",      1'b0, 1'b0, NO_WANT},
    '{CH_SUB,   1'b0, 1'b0, NO_WANT},
    '{"e",      1'b0, 1'b0, NO_WANT},
    '{CH_DIV,   1'b0, 1'b0, NO_WANT},
    '{CH_OPEN,  1'b0, 1'b0, NO_WANT},
    '{"f",      1'b0, 1'b0, NO_WANT},
    '{CH_POW,   1'b0, 1'b0, NO_WANT},
    '{"g",      1'b0, 1'b0, NO_WANT},
    '{CH_CLOSE, 1'b0, 1'b0, NO_WANT},
    // stray close with operators still stacked
    '{CH_CLOSE, 1'b0, 1'b0, NO_WANT},
    '{8'h00,    1'b0, 1'b0, NO_WANT},
    '{8'hFF,    1'b1, 1'b1, '{CH_NONE, 1'b1, STATUS_PAREN, 1'b1}},
    '{CH_CLOSE, 1'b1, 1'b1, '{CH_NONE, 1'b1, STATUS_PAREN, 1'b1}},
    '{CH_OPEN,  1'b1, 1'b1, '{CH_NONE, 1'b1, STATUS_PAREN, 1'b1}},
    '{8'h7F,    1'b1, 1'b1, '{CH_NONE, 1'b1, STATUS_OK,    1'b1}},
    '{"q",      1'b1, 1'b0, NO_WANT}
  };

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_item;

  // Predictor state
  op_code_t   oper_stack [STACK_DEPTH];
  int         oper_depth;
  logic [1:0] expr_status;
  out_beat_t  postfix_q [$];
  out_beat_t  postfix_head;

  logic [7:0] expr_chars [$];
  logic       tx_burst;
  logic       rx_burst;
  int         rand_beats;
  int         n_errors = 0;
  int         n_cycles = 0;

  infix_to_postfix_converter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic is_alpha(input logic [7:0] ch);
    return (ch >= "A" && ch <= "Z") || (ch >= "a" && ch <= "z");
  endfunction

  function automatic op_code_t op_from_char(input logic [7:0] ch);
    case (ch)
      CH_ADD:  return OP_ADD;
      CH_SUB:  return OP_SUB;
      CH_MUL:  return OP_MUL;
      CH_DIV:  return OP_DIV;
      CH_POW:  return OP_POW;
      default: return OP_OPEN;
    endcase
  endfunction

  function automatic logic [7:0] op_glyph(input op_code_t c);
    case (c)
      OP_ADD:  return CH_ADD;
      OP_SUB:  return CH_SUB;
      OP_MUL:  return CH_MUL;
      OP_DIV:  return CH_DIV;
      OP_POW:  return CH_POW;
      default: return CH_OPEN;
    endcase
  endfunction

  function automatic int op_rank(input op_code_t c);
    case (c)
      OP_ADD, OP_SUB: return 1;
      OP_MUL, OP_DIV: return 2;
      OP_POW:         return 3;
      default:        return 0;
    endcase
  endfunction

  function automatic logic is_ignored(input logic [7:0] ch);
    return !is_alpha(ch) && ch != CH_OPEN && ch != CH_CLOSE && op_from_char(ch) == OP_OPEN;
  endfunction

  // Keep the first error of the expression
  function automatic void note_error(input logic [1:0] e);
    if (expr_status == STATUS_OK) expr_status = e;
  endfunction

  function automatic void emit(input logic [7:0] sym, input logic fin, input logic [1:0] st);
    postfix_q.push_back('{out_symbol: sym, end_marker: fin, status: st, last_of_run: 1'b0});
  endfunction

  function automatic void push_op(input op_code_t c);
    if (oper_depth >= STACK_DEPTH) begin
      note_error(STATUS_OVERFLOW);
    end else begin
      oper_stack[oper_depth] = c;
      oper_depth++;
    end
  endfunction

  // Work out the postfix beats caused by one accepted character
  function automatic void convert_char(input logic [7:0] ch, input logic fin,
                                       input logic typed, input out_beat_t want);
    int        n0;
    logic      found;
    op_code_t  nc;
    op_code_t  top;
    out_beat_t tail;
    n0 = postfix_q.size();
    found = 1'b0;
    nc = op_from_char(ch);
    if (is_alpha(ch)) begin
      emit(ch, 1'b0, STATUS_OK);
    end else if (ch == CH_OPEN) begin
      push_op(OP_OPEN);
    end else if (ch == CH_CLOSE) begin
      // pop down to the matching open, which is dropped
      while (oper_depth > 0 && !found) begin
        oper_depth--;
        top = oper_stack[oper_depth];
        if (top == OP_OPEN) found = 1'b1;
        else emit(op_glyph(top), 1'b0, STATUS_OK);
      end
      if (!found) note_error(STATUS_PAREN);
    end else if (nc != OP_OPEN) begin
      // pop every stacked operator of equal or higher rank
      while (oper_depth > 0 && oper_stack[oper_depth-1] != OP_OPEN &&
             op_rank(oper_stack[oper_depth-1]) >= op_rank(nc)) begin
        oper_depth--;
        emit(op_glyph(oper_stack[oper_depth]), 1'b0, STATUS_OK);
      end
      push_op(nc);
    end
    if (fin) begin
      // flush the stack, then close with the status
      while (oper_depth > 0) begin
        oper_depth--;
        top = oper_stack[oper_depth];
        if (top == OP_OPEN) note_error(STATUS_PAREN);
        else emit(op_glyph(top), 1'b0, STATUS_OK);
      end
      emit(CH_NONE, 1'b1, expr_status);
      expr_status = STATUS_OK;
    end
    if (typed) begin
      while (postfix_q.size() > n0) void'(postfix_q.pop_back());
      postfix_q.push_back(want);
    end else if (postfix_q.size() > n0) begin
      tail = postfix_q.pop_back();
      tail.last_of_run = 1'b1;
      postfix_q.push_back(tail);
    end
  endfunction

  // Drive one beat and hold it until accepted
  task automatic send_beat(input logic [7:0] sym, input logic fin,
                           input logic typed, input out_beat_t want);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item  <= '{symbol: sym, final_char: fin};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    convert_char(sym, fin, typed, want);
  endtask

  // Hold off the sender until every expected beat has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (postfix_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_letter();
    logic [7:0] base;
    base = $urandom_range(0, 1) ? "A" : "a";
    return base + 8'($urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 4))
      0:       return CH_ADD;
      1:       return CH_SUB;
      2:       return CH_MUL;
      3:       return CH_DIV;
      default: return CH_POW;
    endcase
  endfunction

  // Build a well-formed expression into expr_chars
  task automatic build_expr(input int max_len, input int max_nest);
    int open_cnt;
    int emitted;
    open_cnt = 0;
    emitted = 0;
    while (1'b1) begin
      while (open_cnt < max_nest && $urandom_range(0, 3) == 0) begin
        expr_chars.push_back(CH_OPEN);
        open_cnt++;
      end
      expr_chars.push_back(rand_letter());
      emitted++;
      while (open_cnt > 0 && $urandom_range(0, 2) == 0) begin
        expr_chars.push_back(CH_CLOSE);
        open_cnt--;
      end
      if (emitted >= max_len) break;
      expr_chars.push_back(rand_op());
    end
    while (open_cnt > 0) begin
      expr_chars.push_back(CH_CLOSE);
      open_cnt--;
    end
  endtask

  // Break or pad the expression now and then
  task automatic mangle_expr();
    int pos;
    pos = $urandom_range(0, expr_chars.size() - 1);
    case ($urandom_range(0, 7))
      0: if (expr_chars.size() > 1) expr_chars.delete(pos);
      1: expr_chars.insert(pos, 8'($urandom_range(0, 255)));
      2: expr_chars.insert(pos, $urandom_range(0, 1) ? CH_OPEN : CH_CLOSE);
      3: expr_chars.insert(pos, 8'h20);
      4: expr_chars.push_back(8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  // Send expr_chars with the final flag on its last character
  task automatic send_expr();
    int k;
    tx_burst = ($urandom_range(0, 3) == 0);
    rx_burst = ($urandom_range(0, 3) == 0);
    for (k = 0; k < expr_chars.size(); k++) begin
      if (!is_ignored(expr_chars[k]) || k == expr_chars.size() - 1) rand_beats++;
      send_beat(expr_chars[k], k == expr_chars.size() - 1, 1'b0, NO_WANT);
    end
    expr_chars.delete();
  endtask

  // Receiver: stall a random number of cycles before each beat
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    while (1'b1) begin
      stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Check each output beat against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (postfix_q.size() == 0) begin
        $display("%0t: unexpected beat sym=%h end=%b st=%0d last=%b", $time,
                 out_item.out_symbol, out_item.end_marker, out_item.status,
                 out_item.last_of_run);
        n_errors++;
      end else begin
        postfix_head = postfix_q.pop_front();
        if (out_item.out_symbol !== postfix_head.out_symbol ||
            out_item.end_marker !== postfix_head.end_marker ||
            out_item.status !== postfix_head.status ||
            out_item.last_of_run !== postfix_head.last_of_run) begin
          $display("%0t: expected sym=%h end=%b st=%0d last=%b, got sym=%h end=%b st=%0d last=%b",
                   $time, postfix_head.out_symbol, postfix_head.end_marker,
                   postfix_head.status, postfix_head.last_of_run, out_item.out_symbol,
                   out_item.end_marker, out_item.status, out_item.last_of_run);
          n_errors++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    n_cycles = n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  initial begin
    int r;
    int n;
    rst         = 1'b1;
    in_valid    = 1'b0;
    in_item     = '0;
    tx_burst    = 1'b0;
    rx_burst    = 1'b0;
    oper_depth  = 0;
    expr_status = STATUS_OK;
    rand_beats  = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed rows
    for (r = 0; r < DIR_ROWS; r++)
      send_beat(DIR_TAB[r].sym, DIR_TAB[r].fin, DIR_TAB[r].typed, DIR_TAB[r].want);
    wait_drained();

    // Overrun the stack with opens
    repeat (STACK_DEPTH + 2) expr_chars.push_back(CH_OPEN);
    expr_chars.push_back("k");
    send_expr();

    // Fill the stack with open and operator pairs, then unwind
    repeat (STACK_DEPTH / 2) begin
      expr_chars.push_back(CH_OPEN);
      expr_chars.push_back(rand_letter());
      expr_chars.push_back(rand_op());
    end
    expr_chars.push_back(rand_letter());
    repeat (STACK_DEPTH / 2) expr_chars.push_back(CH_CLOSE);
    send_expr();

    // Random expressions, mostly well formed
    while (rand_beats < RAND_BEATS) begin
      build_expr($urandom_range(1, 8), $urandom_range(0, 4));
      n = $urandom_range(0, 2);
      repeat (n) mangle_expr();
      send_expr();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    // Drain and report
    in_valid <= 1'b0;
    while (postfix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

// ===== files.f =====
design/itp_pkg.sv
design/itp_stack_mem.sv
design/itp_out_stage.sv
design/itp_ctrl.sv
design/infix_to_postfix_converter.sv
dv/tb.sv
